@@ src/itoa_pkg.sv @@
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd32;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

    localparam int DIGIT_W = $clog2(MAX_RADIX);
    localparam int CHAR_W = 7;
    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
    localparam int DIGIT_CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int STACK_DEPTH = VALUE_WIDTH;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 7'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] digit_ext;
        digit_ext = CHAR_W'(digit);
        if (digit >= DIGIT_TEN)
        begin
            return CHAR_UPPER_A + digit_ext - CHAR_W'(DIGIT_TEN);
        end
        return CHAR_ZERO + digit_ext;
    endfunction

endpackage

@@ src/itoa_div.sv @@
module itoa_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [itoa_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [itoa_pkg::RADIX_W-1:0]     divisor,
    output logic                            done,
    output logic [itoa_pkg::VALUE_WIDTH-1:0] quotient,
    output logic [itoa_pkg::RADIX_W-1:0]     remainder
);
    import itoa_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     div_reg, div_next;
    logic [RADIX_W:0]       trial;
    logic [RADIX_W:0]       trial_diff;

    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial_diff = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = BIT_CNT_W'(VALUE_WIDTH - 1);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle, restoring form.
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial_diff[RADIX_W-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[RADIX_W-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("Divider done without a finished run.");
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < div_reg)
        else $error("Divider remainder not below divisor.");
    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("Divider restarted while busy.");
`endif

endmodule

@@ src/integer_to_ascii_radix_core.sv @@
// Converts a signed integer to ASCII text in a radix from 2 to 32.
// Input channel: value and radix with in_valid and in_stall. A beat is taken
// when in_valid is high and in_stall is low. The block holds in_stall high
// from the cycle after a beat until the last character of that item has been
// loaded into the output register, so it works on one item at a time.
// Output channel: character, last and bad_radix with out_valid and out_stall.
// Each beat carries one character, most significant digit first; last marks
// the final character. A leading minus sign appears only for a negative value
// in radix 10. A radix outside 2 to 32 gives one beat with bad_radix and last
// set and a zero character.
// Digits come from one shared restoring divider that produces one quotient
// bit per cycle. All digits of an item are divided out, least significant
// first, before its first character is loaded into the output register. A
// bad radix skips the divider and goes straight to emitting its one beat.
// When the receiver stalls, the output register holds its beat and the
// character stack waits; nothing is lost. Reset clears the control state and
// drops any item in progress.
module integer_to_ascii_radix_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] value,
    input  logic [itoa_pkg::RADIX_W-1:0]            radix,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]             character,
    output logic                                   last,
    output logic                                   bad_radix
);
    import itoa_pkg::*;

    state_t                 state_reg, state_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   bad_reg, bad_next;
    logic                   neg10_reg, neg10_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [DIGIT_W-1:0]     stack_reg [STACK_DEPTH];
    logic [DIGIT_W-1:0]     stack_next [STACK_DEPTH];

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   bad_out_reg, bad_out_next;

    logic                   in_accept;
    logic                   radix_bad;
    logic [VALUE_WIDTH-1:0] value_u;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   out_load;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [RADIX_W-1:0]     div_rem;

    assign in_stall = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign radix_bad = (radix < MIN_RADIX) || (radix > MAX_RADIX);
    assign value_u = value;
    assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    itoa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_next),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        bad_next = bad_reg;
        neg10_next = neg10_reg;
        radix_next = radix_reg;
        stack_next = stack_reg;
        div_start = 1'b0;
        div_dividend = magnitude;
        char_next = char_reg;
        last_next = last_reg;
        bad_out_next = bad_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cnt_next = '0;
                    radix_next = radix;
                    bad_next = radix_bad;
                    neg10_next = value_u[VALUE_WIDTH-1] && (radix == RADIX_DECIMAL);
                    if (radix_bad)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                div_dividend = div_quo;
                if (div_done)
                begin
                    stack_next[0] = div_rem[DIGIT_W-1:0];
                    for (int i = 1; i < STACK_DEPTH; i++)
                    begin
                        stack_next[i] = stack_reg[i-1];
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (div_quo == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    priority if (bad_reg)
                    begin
                        char_next = CHAR_NONE;
                        last_next = 1'b1;
                        bad_out_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (neg10_reg)
                    begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        bad_out_next = 1'b0;
                        neg10_next = 1'b0;
                    end
                    else
                    begin
                        char_next = digit_char(stack_reg[0]);
                        last_next = (cnt_reg == DIGIT_CNT_W'(1));
                        bad_out_next = 1'b0;
                        for (int i = 0; i < STACK_DEPTH - 1; i++)
                        begin
                            stack_next[i] = stack_reg[i+1];
                        end
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == DIGIT_CNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            bad_reg <= 1'b0;
            neg10_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            bad_reg <= bad_next;
            neg10_reg <= neg10_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        stack_reg <= stack_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_out_reg <= bad_out_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last = last_reg;
    assign bad_radix = bad_out_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("Input not stalled after an accepted beat.");
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_radix) |-> last)
        else $error("Bad radix beat without last.");
    a_digits_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !bad_reg) |-> cnt_reg != '0)
        else $error("Emit state with an empty digit stack.");
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("Divider finished outside the divide state.");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DIGIT_CNT_W'(STACK_DEPTH))
        else $error("Digit count beyond stack depth.");
`endif

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } text_beat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]            radix;
    logic                          out_valid;
    logic                          out_stall;
    logic [CHAR_W-1:0]             character;
    logic                          last;
    logic                          bad_radix;

    text_beat_t pending_text[$];
    logic       no_gaps;
    int         values_sent;
    int         chars_checked;
    int         bad_flags_seen;
    int         mismatch_count;

    integer_to_ascii_radix_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .radix     (radix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last),
        .bad_radix (bad_radix)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Appends the characters that one value must produce, most significant first.
    function automatic void format_value(input logic signed [VALUE_WIDTH-1:0] v,
                                         input logic [RADIX_W-1:0] r);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [VALUE_WIDTH-1:0] base;
        logic [VALUE_WIDTH-1:0] digit;
        logic [CHAR_W-1:0]      text[$];
        if (r < MIN_RADIX || r > MAX_RADIX)
        begin
            pending_text.push_back('{character: CHAR_NONE, last: 1'b1, bad_radix: 1'b1});
            return;
        end
        magnitude = v;
        if (v < 0)
        begin
            magnitude = ~magnitude + 1'b1;
        end
        base = VALUE_WIDTH'(r);
        while (magnitude != 0)
        begin
            digit = magnitude % base;
            if (digit < 10)
            begin
                text.push_front(CHAR_ZERO + CHAR_W'(digit));
            end
            else
            begin
                text.push_front(CHAR_UPPER_A + CHAR_W'(digit - 10));
            end
            magnitude = magnitude / base;
        end
        if (text.size() == 0)
        begin
            text.push_back(CHAR_ZERO);
        end
        if (v < 0 && r == RADIX_DECIMAL)
        begin
            text.push_front(CHAR_MINUS);
        end
        foreach (text[i])
        begin
            pending_text.push_back('{character: text[i], last: (i == text.size() - 1),
                                     bad_radix: 1'b0});
        end
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] pick;
        case ($urandom_range(0, 4))
            0: pick = $urandom;
            1: pick = $urandom_range(0, 40);
            2: pick = 32'h7fff_ffff - $urandom_range(0, 3);
            3: pick = $urandom >> $urandom_range(0, 31);
            default: pick = 32'h8000_0000 + $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1))
        begin
            pick = ~pick + 1'b1;
        end
        return pick;
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        logic [RADIX_W-1:0] r;
        case ($urandom_range(0, 9))
            0: r = RADIX_W'($urandom_range(0, 1));
            1: r = RADIX_W'($urandom_range(33, 63));
            2, 3: r = RADIX_DECIMAL;
            default: r = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
        endcase
        return r;
    endfunction

    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v,
                              input logic [RADIX_W-1:0] r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        radix    <= r;
        do @(posedge clk); while (in_stall);
        format_value(v, r);
        values_sent++;
    endtask

    task automatic drain_text();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_text.size() != 0);
    endtask

    task automatic test_extremes();
        send_value(0, 10);
        send_value(0, 2);
        send_value(1, 2);
        send_value(32'h7fff_ffff, 2);
        send_value(32'h8000_0000, 2);
        send_value(32'h7fff_ffff, 16);
        send_value(32'h8000_0000, 32);
        send_value(-1, 32);
        send_value(31, 32);
        send_value(35, 32);
        send_value(10, 11);
        send_value(32'h7fff_ffff, 10);
    endtask

    task automatic test_bad_radix();
        send_value(5, 0);
        send_value(5, 1);
        send_value(-7, 33);
        send_value(0, 63);
        send_value(32'h8000_0000, 34);
    endtask

    task automatic test_decimal_sign();
        send_value(-1, 10);
        send_value(32'h8000_0000, 10);
        send_value(-1234567890, 10);
        send_value(-255, 16);
        send_value(-9, 9);
        send_value(9, 10);
    endtask

    // The sender holds off until every character of the previous value is out.
    task automatic test_drain_pause();
        repeat (4)
        begin
            send_value(random_value(), random_radix());
            drain_text();
        end
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 300; n++)
        begin
            if (n % 50 == 0)
            begin
                no_gaps = ((n / 50) % 3 == 2);
            end
            send_value(random_value(), random_radix());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int         stall_left;
        text_beat_t want;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                chars_checked++;
                if (pending_text.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: unexpected beat character %0d last %0b bad_radix %0b",
                                 $realtime, character, last, bad_radix);
                    end
                end
                else
                begin
                    want = pending_text.pop_front();
                    if (want.bad_radix)
                    begin
                        bad_flags_seen++;
                    end
                    if (character !== want.character || last !== want.last ||
                        bad_radix !== want.bad_radix)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: expected character %0d last %0b bad_radix %0b, got %0d %0b %0b",
                                     $realtime, want.character, want.last, want.bad_radix,
                                     character, last, bad_radix);
                        end
                    end
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 15);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        radix          = '0;
        no_gaps        = 1'b0;
        values_sent    = 0;
        chars_checked  = 0;
        bad_flags_seen = 0;
        mismatch_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_bad_radix();
        test_decimal_sign();
        test_drain_pause();
        test_random_stream();
        in_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Converted %0d values into %0d output beats, %0d of them bad-radix flags.",
                 values_sent, chars_checked, bad_flags_seen);
        $display("Mismatches seen: %0d.", mismatch_count);
        if (mismatch_count == 0 && pending_text.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("Run timed out with %0d characters outstanding.", pending_text.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
